// ===== hdl/aprq_pkg.sv =====
package aprq_pkg;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned STATUS_W   = 2;

  // effective priority: base minus quotient, signed, never saturated
  localparam int unsigned EFF_W = TIME_W + 2;

  // divider retires this many quotient bits per cycle
  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_ITER  = TIME_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_SELECTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_SEL_SCAN,
    S_SEL_WAIT,
    S_SEL_DIV,
    S_SEL_CMP,
    S_SEL_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
  } slot_t;

endpackage

// ===== hdl/aging_priority_ready_queue_core.sv =====
// Ready table of up to DEPTH tasks with aging priority selection. Each word on the input is an
// insert (func 0) or a select (func 1) and gives exactly one word on the output. Task payloads
// sit in a single-port-read RAM, valid bits in flops. An insert walks the valid bits one slot a
// cycle from slot 0 until it finds a free slot or reports full. A select visits every slot in
// turn: an empty slot is skipped, an occupied one is read from RAM, its wait time is divided by
// the interval in the divider at 2 quotient bits a cycle, and its effective priority is compared;
// the winner is then cleared from the table. The final state moves the result into the output
// register and waits while an earlier result there is still stalled; a new word is taken while an
// earlier result still waits there. The aging interval is written through cfg_we_i; the user must
// write it only while idle, the block itself does not enforce this. Zero disables aging.
module aging_priority_ready_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aprq_pkg::INTERVAL_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [aprq_pkg::ID_W-1:0]           task_id_i,
  input  logic [aprq_pkg::PRIO_W-1:0]         base_priority_i,
  input  logic [aprq_pkg::TIME_W-1:0]         arrival_time_i,
  input  logic [aprq_pkg::TIME_W-1:0]         now_time_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [aprq_pkg::STATUS_W-1:0]       status_o,
  output logic [aprq_pkg::ID_W-1:0]           chosen_id_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  aprq_pkg::state_e state_q, state_d;

  logic [IW-1:0]                       idx_q, idx_d;
  logic [DEPTH-1:0]                    valid_q, valid_d;
  logic [aprq_pkg::INTERVAL_W-1:0]     interval_q, interval_d;

  logic [aprq_pkg::ID_W-1:0]           item_id_q, item_id_d;
  logic [aprq_pkg::PRIO_W-1:0]         item_prio_q, item_prio_d;
  logic [aprq_pkg::TIME_W-1:0]         item_arr_q, item_arr_d;
  logic [aprq_pkg::TIME_W-1:0]         now_q, now_d;

  logic                                have_best_q, have_best_d;
  logic [IW-1:0]                       best_idx_q, best_idx_d;
  logic signed [aprq_pkg::EFF_W-1:0]   best_eff_q, best_eff_d;
  logic [aprq_pkg::TIME_W-1:0]         best_arr_q, best_arr_d;
  logic [aprq_pkg::ID_W-1:0]           best_id_q, best_id_d;

  aprq_pkg::status_e                   res_status_q, res_status_d;
  logic [aprq_pkg::ID_W-1:0]           res_id_q, res_id_d;

  logic                                out_valid_q, out_valid_d;
  aprq_pkg::status_e                   out_status_q, out_status_d;
  logic [aprq_pkg::ID_W-1:0]           out_id_q, out_id_d;

  logic                                in_accept;
  logic                                out_free;
  logic                                last;

  logic                                ram_we;
  logic                                ram_re;
  aprq_pkg::slot_t                     ram_wdata;
  logic [$bits(aprq_pkg::slot_t)-1:0]  ram_rdata;
  aprq_pkg::slot_t                     rd_slot;

  logic                                div_start;
  logic                                div_busy;
  logic [aprq_pkg::TIME_W-1:0]         div_quotient;
  logic [aprq_pkg::TIME_W-1:0]         wait_time;
  logic [aprq_pkg::TIME_W-1:0]         bonus;
  logic signed [aprq_pkg::EFF_W-1:0]   eff;
  logic                                better;

  assign in_stall_o = (state_q != aprq_pkg::S_IDLE);
  assign in_accept  = in_valid_i && (state_q == aprq_pkg::S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last       = (idx_q == IW'(DEPTH - 1));

  assign ram_wdata = '{id: item_id_q, prio: item_prio_q, arrival: item_arr_q};
  assign rd_slot   = aprq_pkg::slot_t'(ram_rdata);

  aprq_ram #(
    .WIDTH ($bits(aprq_pkg::slot_t)),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // a task that arrived after now has not waited at all
  assign wait_time = (now_q > rd_slot.arrival) ? (now_q - rd_slot.arrival) : '0;

  aprq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wait_time),
    .divisor_i  (interval_q),
    .busy_o     (div_busy),
    .quotient_o (div_quotient)
  );

  assign bonus = (interval_q == '0) ? '0 : div_quotient;
  assign eff   = $signed({2'b00, aprq_pkg::TIME_W'(rd_slot.prio)}) - $signed({2'b00, bonus});

  // lower effective priority wins, then earlier arrival, then lower id
  always_comb begin
    priority if (!have_best_q) begin
      better = 1'b1;
    end else if (eff != best_eff_q) begin
      better = (eff < best_eff_q);
    end else if (rd_slot.arrival != best_arr_q) begin
      better = (rd_slot.arrival < best_arr_q);
    end else begin
      better = (rd_slot.id < best_id_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aprq_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (func_i == aprq_pkg::FUNC_SELECT) ? aprq_pkg::S_SEL_SCAN
                                                      : aprq_pkg::S_INS_SCAN;
        end
      end
      aprq_pkg::S_INS_SCAN: begin
        if (!valid_q[idx_q] || last) begin
          state_d = aprq_pkg::S_DONE;
        end
      end
      aprq_pkg::S_SEL_SCAN: begin
        if (valid_q[idx_q]) begin
          state_d = aprq_pkg::S_SEL_WAIT;
        end else if (last) begin
          state_d = aprq_pkg::S_SEL_END;
        end
      end
      aprq_pkg::S_SEL_WAIT: state_d = aprq_pkg::S_SEL_DIV;
      aprq_pkg::S_SEL_DIV: begin
        if (!div_busy) begin
          state_d = aprq_pkg::S_SEL_CMP;
        end
      end
      aprq_pkg::S_SEL_CMP: begin
        state_d = last ? aprq_pkg::S_SEL_END : aprq_pkg::S_SEL_SCAN;
      end
      aprq_pkg::S_SEL_END: state_d = aprq_pkg::S_DONE;
      aprq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = aprq_pkg::S_IDLE;
        end
      end
      default: state_d = aprq_pkg::S_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    idx_d        = idx_q;
    valid_d      = valid_q;
    interval_d   = interval_q;
    item_id_d    = item_id_q;
    item_prio_d  = item_prio_q;
    item_arr_d   = item_arr_q;
    now_d        = now_q;
    have_best_d  = have_best_q;
    best_idx_d   = best_idx_q;
    best_eff_d   = best_eff_q;
    best_arr_d   = best_arr_q;
    best_id_d    = best_id_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_start    = 1'b0;

    if (cfg_we_i) begin
      interval_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      aprq_pkg::S_IDLE: begin
        if (in_accept) begin
          item_id_d   = task_id_i;
          item_prio_d = base_priority_i;
          item_arr_d  = arrival_time_i;
          now_d       = now_time_i;
          idx_d       = '0;
          have_best_d = 1'b0;
        end
      end
      aprq_pkg::S_INS_SCAN: begin
        if (!valid_q[idx_q]) begin
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          res_status_d   = aprq_pkg::ST_INSERTED;
          res_id_d       = '0;
        end else if (last) begin
          res_status_d = aprq_pkg::ST_FULL;
          res_id_d     = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      aprq_pkg::S_SEL_SCAN: begin
        if (valid_q[idx_q]) begin
          ram_re = 1'b1;
        end else if (!last) begin
          idx_d = idx_q + 1'b1;
        end
      end
      aprq_pkg::S_SEL_WAIT: begin
        div_start = 1'b1;
      end
      aprq_pkg::S_SEL_DIV: begin
      end
      aprq_pkg::S_SEL_CMP: begin
        if (better) begin
          have_best_d = 1'b1;
          best_idx_d  = idx_q;
          best_eff_d  = eff;
          best_arr_d  = rd_slot.arrival;
          best_id_d   = rd_slot.id;
        end
        if (!last) begin
          idx_d = idx_q + 1'b1;
        end
      end
      aprq_pkg::S_SEL_END: begin
        if (have_best_q) begin
          valid_d[best_idx_q] = 1'b0;
          res_status_d        = aprq_pkg::ST_SELECTED;
          res_id_d            = best_id_q;
        end else begin
          res_status_d = aprq_pkg::ST_EMPTY;
          res_id_d     = '0;
        end
      end
      aprq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aprq_pkg::S_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      interval_q  <= aprq_pkg::INTERVAL_RESET;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      interval_q  <= interval_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_id_q    <= item_id_d;
    item_prio_q  <= item_prio_d;
    item_arr_q   <= item_arr_d;
    now_q        <= now_d;
    best_idx_q   <= best_idx_d;
    best_eff_q   <= best_eff_d;
    best_arr_q   <= best_arr_d;
    best_id_q    <= best_id_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign chosen_id_o = out_id_q;

endmodule

// ===== hdl/aprq_ram.sv =====
module aprq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/aprq_div.sv =====
module aprq_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [aprq_pkg::TIME_W-1:0]       dividend_i,
  input  logic [aprq_pkg::INTERVAL_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic [aprq_pkg::TIME_W-1:0]       quotient_o
);

  logic                                busy_q, busy_d;
  logic [aprq_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [aprq_pkg::TIME_W-1:0]         dvd_q, dvd_d;
  logic [aprq_pkg::TIME_W-1:0]         quo_q, quo_d;
  logic [aprq_pkg::INTERVAL_W-1:0]     div_q, div_d;
  logic [aprq_pkg::INTERVAL_W-1:0]     rem_q, rem_d;

  // restoring division, a few quotient bits per cycle
  always_comb begin
    logic [aprq_pkg::INTERVAL_W:0]   r;
    logic [aprq_pkg::INTERVAL_W-1:0] rem;
    logic [aprq_pkg::TIME_W-1:0]     dvd;
    logic [aprq_pkg::TIME_W-1:0]     quo;
    logic                            ge;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem    = rem_q;
    dvd    = dvd_q;
    quo    = quo_q;
    for (int j = 0; j < aprq_pkg::DIV_BITS; j++) begin
      r   = {rem, dvd[aprq_pkg::TIME_W-1]};
      dvd = {dvd[aprq_pkg::TIME_W-2:0], 1'b0};
      ge  = (r >= {1'b0, div_q});
      if (ge) begin
        r = r - {1'b0, div_q};
      end
      rem = r[aprq_pkg::INTERVAL_W-1:0];
      quo = {quo[aprq_pkg::TIME_W-2:0], ge};
    end
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      dvd_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = rem;
      dvd_d = dvd;
      quo_d = quo;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == aprq_pkg::DIV_CNT_W'(aprq_pkg::DIV_ITER - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
